// ===== hdl/indexed_array_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// indexed_array_list_engine_assert.svh
// Assertion macros for the indexed array list engine. The bodies are empty
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ARRAY_LIST_ENGINE_ASSERT_SVH
`define INDEXED_ARRAY_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTH
// clocked property, disabled while reset is high
`define IAE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked property, checked during reset too
`define IAE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IAE_ASSERT(lbl, clk, rst, prop, msg)
`define IAE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/iae_pkg.sv =====
// ----------------------------------------------------------------------------
// iae_pkg
// Shared types and constants of the indexed array list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iae_pkg;

   // field widths of the request and response transfers
   localparam int CMD_W     = 3;
   localparam int POS_W     = 9;
   localparam int DATA_W    = 32;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 9;

   // default store depth
   localparam int DEPTH_DEF = 256;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND    = 3'd0,
      CMD_INSERT    = 3'd1,
      CMD_DELETE    = 3'd2,
      CMD_OVERWRITE = 3'd3,
      CMD_READ      = 3'd4,
      CMD_LENGTH    = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_SHIFT,
      S_INS_LAST,
      S_DEL_SHIFT,
      S_RD_WAIT,
      S_FINISH
   } state_type;

   // memory port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

// ===== hdl/iae_mem.sv =====
// ----------------------------------------------------------------------------
// iae_mem
// Element store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iae_mem
   import iae_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  mem_ctl_type       mem_ctl,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] store_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/iae_ctrl.sv =====
// ----------------------------------------------------------------------------
// iae_ctrl
// Command sequencer: range checks, entry count, shift loops over the store
// and the response output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iae_ctrl
   import iae_pkg::*;
#(
   parameter int DEPTH  = DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_data_value,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [CNT_OUT_W-1:0]     rsp_entry_count,
   // store port
   output mem_ctl_type              mem_ctl,
   output logic [ADDR_W-1:0]        wr_addr,
   output logic [DATA_W-1:0]        wr_data,
   output logic [ADDR_W-1:0]        rd_addr,
   input  logic [DATA_W-1:0]        rd_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        idx_ff, idx_in;
   logic [ADDR_W-1:0]        pos_ff, pos_in;
   logic [DATA_W-1:0]        val_ff, val_in;
   status_type               status_ff, status_in;
   logic [DATA_W-1:0]        rdval_ff, rdval_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]        rsp_rdval_ff, rsp_rdval_in;
   logic [CNT_OUT_W-1:0]     rsp_count_ff, rsp_count_in;

   logic [CMP_W-1:0]         pos_c;
   logic [CMP_W-1:0]         cnt_c;
   logic                     full_c;
   logic [CNT_W:0]           del_next_c;

   // compare operands at a common width
   assign pos_c      = CMP_W'(req_position);
   assign cnt_c      = CMP_W'(count_ff);
   assign full_c     = (count_ff == CNT_W'(DEPTH));
   assign del_next_c = (CNT_W + 1)'(idx_ff) + (CNT_W + 1)'(2);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      rdval_ff      <= rdval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rdval_ff  <= rsp_rdval_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // next state, store accesses and response load
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      rdval_in      = rdval_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_rdval_in  = rsp_rdval_ff;
      rsp_count_in  = rsp_count_ff;
      mem_ctl       = '0;
      wr_addr       = pos_ff;
      wr_data       = val_ff;
      rd_addr       = pos_ff;
      req_ready     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               pos_in    = ADDR_W'(req_position);
               val_in    = req_data_value;
               status_in = ST_OK;
               rdval_in  = '0;
               state_in  = S_FINISH;
               case (req_command)
                  CMD_APPEND: begin
                     if (full_c) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = ADDR_W'(count_ff);
                        wr_data       = req_data_value;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_INSERT: begin
                     if (pos_c > cnt_c) begin
                        status_in = ST_RANGE;
                     end else if (full_c) begin
                        status_in = ST_FULL;
                     end else if (pos_c == cnt_c) begin
                        // insert at the end: same as append
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = ADDR_W'(count_ff);
                        wr_data       = req_data_value;
                        count_in      = count_ff + CNT_W'(1);
                     end else begin
                        // start moving entries up from the top
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = ADDR_W'(count_ff - CNT_W'(1));
                        idx_in        = ADDR_W'(count_ff);
                        state_in      = S_INS_SHIFT;
                     end
                  end
                  CMD_DELETE: begin
                     if (pos_c >= cnt_c) begin
                        status_in = ST_RANGE;
                     end else if (CMP_W'(pos_c + CMP_W'(1)) == cnt_c) begin
                        // last entry: nothing to move
                        count_in = count_ff - CNT_W'(1);
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = ADDR_W'(pos_c + CMP_W'(1));
                        idx_in        = ADDR_W'(req_position);
                        state_in      = S_DEL_SHIFT;
                     end
                  end
                  CMD_OVERWRITE: begin
                     if (pos_c >= cnt_c) begin
                        status_in = ST_RANGE;
                     end else begin
                        mem_ctl.wr_en = 1'b1;
                        wr_addr       = ADDR_W'(req_position);
                        wr_data       = req_data_value;
                     end
                  end
                  CMD_READ: begin
                     if (pos_c >= cnt_c) begin
                        status_in = ST_RANGE;
                     end else begin
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = ADDR_W'(req_position);
                        state_in      = S_RD_WAIT;
                     end
                  end
                  default: begin
                     // read length and unused codes: report only
                  end
               endcase
            end
         end

         // entry idx-1 arrived: store at idx, fetch idx-2 unless idx-1 is the position
         S_INS_SHIFT: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = idx_ff;
            wr_data       = rd_data;
            if (ADDR_W'(idx_ff - ADDR_W'(1)) == pos_ff) begin
               state_in = S_INS_LAST;
            end else begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = ADDR_W'(idx_ff - ADDR_W'(2));
               idx_in        = ADDR_W'(idx_ff - ADDR_W'(1));
            end
         end

         // gap opened: place the new word
         S_INS_LAST: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = pos_ff;
            wr_data       = val_ff;
            count_in      = count_ff + CNT_W'(1);
            state_in      = S_FINISH;
         end

         // entry idx+1 arrived: store at idx, fetch idx+2 if in use
         S_DEL_SHIFT: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = idx_ff;
            wr_data       = rd_data;
            if (del_next_c < {1'b0, count_ff}) begin
               mem_ctl.rd_en = 1'b1;
               rd_addr       = ADDR_W'(del_next_c);
               idx_in        = ADDR_W'(idx_ff + ADDR_W'(1));
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_FINISH;
            end
         end

         S_RD_WAIT: begin
            rdval_in = rd_data;
            state_in = S_FINISH;
         end

         // hand the result to the output register once it is free
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_rdval_in  = rdval_ff;
               rsp_count_in  = CNT_OUT_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_rdval_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== hdl/indexed_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_array_list_engine
// Ordered list of signed 32-bit words held in a single-port-pair store.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries a command, a position and
//   a data word; the response channel (rsp_valid/rsp_ready) returns one
//   status, read value and entry count per request transfer.
//   One command is processed at a time; req_ready is high only while idle.
//   Append, overwrite, read length and refused commands go straight to the
//   finish state, and read first waits for the registered read data.
//   Insert and delete step through the entries between the position and
//   the top of the list; an insert at the end acts as an append, and a
//   delete of the last entry has nothing to move.
//   Insert and delete move one entry per cycle through the store's single
//   read and single write port.
//   The next request is taken in the cycle after a response is loaded.
//   A finished response sits in an output register; a new request is taken
//   while it waits. If the receiver stalls, the next command finishes and
//   then holds until the output register is free.
//   Reset clears the entry count and the control state; the store contents
//   are left as they are, since entries at or above the count are never read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "indexed_array_list_engine_assert.svh"

module indexed_array_list_engine
   import iae_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [CMD_W-1:0]         req_command,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_data_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [CNT_OUT_W-1:0]     rsp_entry_count
);

   localparam int ADDR_W = $clog2(DEPTH);

   mem_ctl_type       mem_ctl;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;

   // sequencer
   iae_ctrl #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_data_value  (req_data_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .mem_ctl         (mem_ctl),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   // element store
   iae_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // one command at a time: ready drops after each request transfer
   `IAE_ASSERT(a_busy_after_req, clock, reset, req_valid && req_ready |=> !req_ready,
               "ready stayed high after a request transfer")
   // a refused command never returns data
   `IAE_ASSERT(a_err_zero_data, clock, reset,
               rsp_valid && (rsp_status != ST_OK) |-> rsp_read_value == '0,
               "nonzero read value with an error status")
   // reset leaves the engine idle with no pending response
   `IAE_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> req_ready && !rsp_valid,
                      "engine not idle after reset")

endmodule
